// ----- design/directional_sprite_frame_selector_top_defines.svh -----
// Assertion macros for the directional sprite frame selector.
`ifndef DIRECTIONAL_SPRITE_FRAME_SELECTOR_TOP_DEFINES_SVH
`define DIRECTIONAL_SPRITE_FRAME_SELECTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DSFS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsfs assertion failed");
`define DSFS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsfs assertion failed");
`else
`define DSFS_ASSERT_IMP(label, ante, cons)
`define DSFS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- design/dsfs_pkg.sv -----
// Shared types and constants of the directional sprite frame selector.
package dsfs_pkg;

	localparam int NUM_DIRECTIONS = 8;
	localparam int SECTOR_W = $clog2(NUM_DIRECTIONS);

	localparam int DIV_W = 40;
	localparam int DIVISOR_W = 32;
	localparam int DIV_STEPS = DIV_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_PLAY = 2'd1;
	localparam logic [1:0] REQ_PAUSE = 2'd2;

	localparam logic [1:0] REG_ANIM_PERIOD = 2'd0;
	localparam logic [1:0] REG_PLAY_ONCE = 2'd1;
	localparam logic [1:0] REG_FRAMES_PER_DIR = 2'd2;

	localparam logic [31:0] ANIM_PERIOD_RESET = 32'd1000000;

	localparam logic [SECTOR_W-1:0] SECTOR_ZERO_VEC = 3'd6;

	typedef struct packed {
		logic [1:0] req_type;
		logic [15:0] elapsed_time;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
	} in_item_t;

	typedef struct packed {
		logic [10:0] frame_index;
		logic [SECTOR_W-1:0] dir_sector;
		logic still_playing;
		logic frame_error;
	} out_item_t;

endpackage

// ----- design/dsfs_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module dsfs_div
	import dsfs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIV_W-1:0] dividend,
	input logic [DIVISOR_W-1:0] divisor,
	output logic done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIVISOR_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [DIVISOR_W:0] shifted;
	logic [DIVISOR_W+1:0] diff;
	logic fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff = {1'b0, shifted} - {2'b00, divisor};
	assign fits = ~diff[DIVISOR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				quo_q <= dividend;
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ----- design/directional_sprite_frame_selector_top.sv -----
// Top level of the directional sprite frame selector.
//
//  channel  signals                              direction
//  in       in_valid, in_ready, in_data          item in
//  out      out_valid, out_ready, out_data       result out
//  cfg      cfg_we, cfg_index, cfg_data          register write
//
// A tick taken while playing occupies the block from its transfer in until its
// result is written to the output register: four passes through the shared
// multiplier, the sector compare, then a fifth pass for sector*frames while the
// 40-step serial divider computes time*frames/period. Play, pause and ignored
// items leave the block idle. A finished result waits in the output register; a
// stalled output blocks only the next result, not the next transfer in.
// Reset clears the played time, pauses playback and loads register defaults.
`include "directional_sprite_frame_selector_top_defines.svh"

module directional_sprite_frame_selector_top
	import dsfs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_S,
		S_MUL_A,
		S_MUL_B,
		S_MUL_F,
		S_SECT,
		S_FSEC,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	logic [31:0] anim_period_q;
	logic play_once_q;
	logic [7:0] frames_q;

	logic [31:0] played_time_q;
	logic playing_q;

	logic [16:0] a_q;
	logic [16:0] b_q;
	logic x_pos_q;
	logic y_pos_q;
	logic y_zero_q;
	logic zero_vec_q;
	logic [32:0] s_q;
	logic [30:0] sa_q;
	logic [30:0] sb_q;
	logic [SECTOR_W-1:0] sec_q;
	logic [DIV_W-1:0] mul_q;

	logic out_valid_q;
	out_item_t out_q;

	logic accept;
	logic [32:0] sum;
	logic [16:0] x_ext;
	logic [16:0] y_ext;
	logic [16:0] ab_sum;
	logic [31:0] op_a;
	logic [16:0] op_b;
	logic [48:0] product;
	logic [32:0] two_a;
	logic [32:0] two_b;
	logic [2:0] k;
	logic [SECTOR_W-1:0] sector;
	logic div_start;
	logic div_done;
	logic [DIV_W-1:0] quotient;
	logic [7:0] idx;
	logic out_free;

	assign accept = in_valid && in_ready;
	assign sum = {1'b0, played_time_q} + {17'd0, in_data.elapsed_time};
	assign x_ext = {in_data.dir_x[15], in_data.dir_x};
	assign y_ext = {in_data.dir_y[15], in_data.dir_y};
	assign ab_sum = a_q + b_q;

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_MUL_S: begin
				op_a = {15'd0, ab_sum};
				op_b = ab_sum;
			end
			S_MUL_A: begin
				op_a = {15'd0, a_q};
				op_b = a_q;
			end
			S_MUL_B: begin
				op_a = {15'd0, b_q};
				op_b = b_q;
			end
			S_MUL_F: begin
				op_a = played_time_q;
				op_b = {9'd0, frames_q};
			end
			S_FSEC, S_DIV, S_FIN: begin
				op_a = {{(32-SECTOR_W){1'b0}}, sec_q};
				op_b = {9'd0, frames_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign product = op_a * op_b;

	always_ff @(posedge clk) begin
		mul_q <= product[DIV_W-1:0];
	end

	assign two_a = {1'b0, sa_q, 1'b0};
	assign two_b = {1'b0, sb_q, 1'b0};

	always_comb begin
		priority if (y_pos_q) begin
			k = (s_q < two_b) ? 3'd0 : ((s_q > two_a) ? 3'd1 : 3'd2);
		end else if (y_zero_q) begin
			k = 3'd2;
		end else begin
			k = (s_q < two_a) ? 3'd2 : ((s_q > two_b) ? 3'd3 : 3'd4);
		end
		priority if (zero_vec_q) begin
			sector = SECTOR_ZERO_VEC;
		end else if (k == 3'd0 || k == 3'd4 || x_pos_q) begin
			sector = k;
		end else begin
			sector = SECTOR_W'(NUM_DIRECTIONS) - k;
		end
	end

	assign div_start = (state_q == S_SECT);

	dsfs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(mul_q),
		.divisor(anim_period_q),
		.done(div_done),
		.quotient(quotient)
	);

	assign idx = (quotient < {32'd0, frames_q}) ? quotient[7:0] : (frames_q - 8'd1);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anim_period_q <= ANIM_PERIOD_RESET;
			play_once_q <= 1'b0;
			frames_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANIM_PERIOD: anim_period_q <= cfg_data;
				REG_PLAY_ONCE: play_once_q <= cfg_data[0];
				REG_FRAMES_PER_DIR: frames_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			played_time_q <= '0;
			playing_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			x_pos_q <= 1'b0;
			y_pos_q <= 1'b0;
			y_zero_q <= 1'b0;
			zero_vec_q <= 1'b0;
			s_q <= '0;
			sa_q <= '0;
			sb_q <= '0;
			sec_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (in_data.req_type == REQ_PLAY) begin
							playing_q <= 1'b1;
						end else if (in_data.req_type == REQ_PAUSE) begin
							playing_q <= 1'b0;
						end else if (in_data.req_type == REQ_TICK && playing_q) begin
							if (sum > {1'b0, anim_period_q}) begin
								if (play_once_q) begin
									playing_q <= 1'b0;
									played_time_q <= anim_period_q;
								end else begin
									played_time_q <= '0;
								end
							end else begin
								played_time_q <= sum[31:0];
							end
							a_q <= x_ext[16] ? (17'd0 - x_ext) : x_ext;
							b_q <= y_ext[16] ? (17'd0 - y_ext) : y_ext;
							x_pos_q <= !in_data.dir_x[15] && (in_data.dir_x != 16'sd0);
							y_pos_q <= !in_data.dir_y[15] && (in_data.dir_y != 16'sd0);
							y_zero_q <= (in_data.dir_y == 16'sd0);
							zero_vec_q <= (in_data.dir_x == 16'sd0) && (in_data.dir_y == 16'sd0);
							state_q <= S_MUL_S;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_MUL_S: state_q <= S_MUL_A;
				S_MUL_A: begin
					s_q <= mul_q[32:0];
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					sa_q <= mul_q[30:0];
					state_q <= S_MUL_F;
				end
				S_MUL_F: begin
					sb_q <= mul_q[30:0];
					state_q <= S_SECT;
				end
				S_SECT: begin
					sec_q <= sector;
					state_q <= S_FSEC;
				end
				S_FSEC: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.frame_index <= (frames_q == 8'd0) ? 11'd0
							: (mul_q[10:0] + {3'd0, idx});
						out_q.dir_sector <= sec_q;
						out_q.still_playing <= playing_q;
						out_q.frame_error <= (frames_q == 8'd0);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`DSFS_ASSERT_IMP(a_err_zero_frame, out_valid && out_data.frame_error, out_data.frame_index == 11'd0)
	`DSFS_ASSERT_IMP(a_time_in_period, state_q != S_IDLE, played_time_q <= anim_period_q)
	`DSFS_ASSERT_NXT(a_tick_busy, accept && in_data.req_type == REQ_TICK && playing_q, !in_ready)
	`DSFS_ASSERT_IMP(a_div_done_state, div_done, state_q == S_DIV)

endmodule
